@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on the rising clock edge and switched off during reset.
`define ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Assertion sampled on the rising clock edge, also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

@@ design/cats_pkg.sv @@
// ----------------------------------------------------------------------------
// Column-associative tag store package
// Request and response types, sequencer states and outcome codes.
// ----------------------------------------------------------------------------
`default_nettype none

package cats_pkg;

   localparam logic [2:0] CMD_FETCH = 3'd2;

   typedef enum logic [2:0] {
      OUT_IGNORED   = 3'd0,
      OUT_PRI_HIT   = 3'd1,
      OUT_ALT_HIT   = 3'd2,
      OUT_MISS_FILL = 3'd3,
      OUT_MISS_REPL = 3'd4
   } outcome_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PRI,
      ST_ALT,
      ST_SWAP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic [2:0]  outcome;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
   } rsp_type;

endpackage

`default_nettype wire

@@ design/column_associative_tag_store.sv @@
// Sequence: a non-fetch command goes from idle to done; a fetch goes to PRI, which
// ends a primary hit or fill in done and sends other misses to ALT, which ends an
// alternate miss in done and an alternate hit in SWAP, then done. Only idle takes a
// new request; the sequencer takes the probes and swap writes one after another.
// Reset: synchronous; a clearing pass over all 2**INDEX_BITS lines (256 by default)
// zeroes the tag RAM while req_ready stays low.
// ----------------------------------------------------------------------------
// Column-associative tag store
// Direct-mapped instruction tag RAM with a second probe at the inverted index.
// ----------------------------------------------------------------------------
`default_nettype none

module column_associative_tag_store #(
   parameter int INDEX_BITS  = 8,
   parameter int TAG_BITS    = 19,
   parameter int OFFSET_BITS = 5
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire cats_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output cats_pkg::rsp_type      rsp_data
);

   localparam int LINES   = 1 << INDEX_BITS;
   localparam int SPAN    = OFFSET_BITS + INDEX_BITS + TAG_BITS;
   localparam int EXT_W   = (SPAN > 32) ? SPAN : 32;

   logic [TAG_BITS-1:0]   mem [LINES];

   cats_pkg::state_type   state_ff, state_in;
   logic [INDEX_BITS-1:0] clr_ff, clr_in;
   logic [INDEX_BITS-1:0] idx_ff;
   logic [TAG_BITS-1:0]   tag_ff;
   logic [TAG_BITS-1:0]   prim_ff;
   logic [TAG_BITS-1:0]   rd_ff;
   cats_pkg::outcome_type outcome_ff, outcome_in;
   logic [31:0]           hit_ff, hit_in;
   logic [31:0]           miss_ff, miss_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   cats_pkg::rsp_type     rsp_data_ff;

   logic [EXT_W-1:0]      addr_ext;
   logic [INDEX_BITS-1:0] req_idx;
   logic [TAG_BITS-1:0]   req_tag;
   logic                  req_fire;
   logic                  cmp_eq;
   logic                  rd_zero;
   logic                  wr_en;
   logic [INDEX_BITS-1:0] wr_addr;
   logic [TAG_BITS-1:0]   wr_data;
   logic                  rd_en;
   logic [INDEX_BITS-1:0] rd_addr;
   logic                  load_rsp;
   logic                  is_hit;
   logic                  is_miss;

   // Address bits above bit 31 read as zero when the fields reach past it.
   assign addr_ext = EXT_W'(req_data.address);
   assign req_idx  = addr_ext[OFFSET_BITS +: INDEX_BITS];
   assign req_tag  = addr_ext[OFFSET_BITS + INDEX_BITS +: TAG_BITS];
   assign req_fire = req_valid && req_ready;

   // The one comparator serves both the primary and the alternate probe.
   assign cmp_eq  = (rd_ff == tag_ff);
   assign rd_zero = (rd_ff == '0);

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      outcome_in = outcome_ff;
      req_ready  = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = tag_ff;
      rd_en      = 1'b0;
      rd_addr    = req_idx;
      load_rsp   = 1'b0;
      case (state_ff)
         cats_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + INDEX_BITS'(1);
            if (clr_ff == '1) begin
               state_in = cats_pkg::ST_IDLE;
            end
         end
         cats_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            rd_en      = req_valid;
            outcome_in = cats_pkg::OUT_IGNORED;
            if (req_valid) begin
               if (req_data.cmd == cats_pkg::CMD_FETCH) begin
                  state_in = cats_pkg::ST_PRI;
               end else begin
                  state_in = cats_pkg::ST_DONE;
               end
            end
         end
         cats_pkg::ST_PRI: begin
            if (cmp_eq) begin
               outcome_in = cats_pkg::OUT_PRI_HIT;
               state_in   = cats_pkg::ST_DONE;
            end else if (rd_zero) begin
               wr_en      = 1'b1;
               outcome_in = cats_pkg::OUT_MISS_FILL;
               state_in   = cats_pkg::ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = ~idx_ff;
               state_in = cats_pkg::ST_ALT;
            end
         end
         cats_pkg::ST_ALT: begin
            wr_en   = 1'b1;
            wr_addr = ~idx_ff;
            if (cmp_eq) begin
               // The primary's old tag moves over; the primary is written next.
               wr_data    = prim_ff;
               outcome_in = cats_pkg::OUT_ALT_HIT;
               state_in   = cats_pkg::ST_SWAP;
            end else begin
               outcome_in = cats_pkg::OUT_MISS_REPL;
               state_in   = cats_pkg::ST_DONE;
            end
         end
         cats_pkg::ST_SWAP: begin
            wr_en    = 1'b1;
            state_in = cats_pkg::ST_DONE;
         end
         cats_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = cats_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cats_pkg::ST_IDLE;
         end
      endcase
   end

   assign is_hit  = (outcome_ff == cats_pkg::OUT_PRI_HIT) ||
                    (outcome_ff == cats_pkg::OUT_ALT_HIT);
   assign is_miss = (outcome_ff == cats_pkg::OUT_MISS_FILL) ||
                    (outcome_ff == cats_pkg::OUT_MISS_REPL);

   always_comb begin
      hit_in       = hit_ff;
      miss_in      = miss_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp && is_hit && (hit_ff != '1)) begin
         hit_in = hit_ff + 32'd1;
      end
      if (load_rsp && is_miss && (miss_ff != '1)) begin
         miss_in = miss_ff + 32'd1;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cats_pkg::ST_CLEAR;
         clr_ff       <= '0;
         hit_ff       <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hit_ff       <= hit_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      outcome_ff <= outcome_in;
      if (req_fire) begin
         idx_ff <= req_idx;
         tag_ff <= req_tag;
      end
      if (state_ff == cats_pkg::ST_PRI) begin
         prim_ff <= rd_ff;
      end
      if (load_rsp) begin
         rsp_data_ff.outcome    <= outcome_ff;
         rsp_data_ff.hit_total  <= hit_in;
         rsp_data_ff.miss_total <= miss_in;
      end
   end

   // Tag RAM: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ design/cats_checker.sv @@
// ----------------------------------------------------------------------------
// Column-associative tag store checker
// Port-level checks on the response stream and its running counts.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cats_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire cats_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire cats_pkg::rsp_type rsp_data
);

   logic [31:0] last_hit_ff;
   logic [31:0] last_miss_ff;
   logic [1:0]  pending_ff, pending_in;
   logic        req_fire;
   logic        rsp_fire;
   logic        rsp_ignored;
   logic        rsp_hit;
   logic        rsp_miss;

   assign req_fire    = req_valid && req_ready;
   assign rsp_fire    = rsp_valid && rsp_ready;
   assign rsp_ignored = (rsp_data.outcome == cats_pkg::OUT_IGNORED);
   assign rsp_hit     = (rsp_data.outcome == cats_pkg::OUT_PRI_HIT) ||
                        (rsp_data.outcome == cats_pkg::OUT_ALT_HIT);
   assign rsp_miss    = (rsp_data.outcome == cats_pkg::OUT_MISS_FILL) ||
                        (rsp_data.outcome == cats_pkg::OUT_MISS_REPL);

   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_fire && rsp_fire) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_hit_ff  <= '0;
         last_miss_ff <= '0;
         pending_ff   <= '0;
      end else begin
         pending_ff <= pending_in;
         if (rsp_fire) begin
            last_hit_ff  <= rsp_data.hit_total;
            last_miss_ff <= rsp_data.miss_total;
         end
      end
   end

   // Every response belongs to a request that has not yet been answered.
   `ASSERT_RST(a_rsp_has_request, clock, reset, rsp_valid |-> (pending_ff != 2'd0))

   `ASSERT_RST(a_rsp_holds, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))

   // An ignored request leaves both counts as the previous response left them.
   `ASSERT_RST(a_ignored_counts, clock, reset, rsp_fire && rsp_ignored |->
      (rsp_data.hit_total == last_hit_ff) && (rsp_data.miss_total == last_miss_ff))

   `ASSERT_RST(a_hit_counts, clock, reset, rsp_fire && rsp_hit |->
      (rsp_data.miss_total == last_miss_ff) &&
      ((rsp_data.hit_total == last_hit_ff + 32'd1) ||
       ((last_hit_ff == '1) && (rsp_data.hit_total == '1))))

   `ASSERT_RST(a_miss_counts, clock, reset, rsp_fire && rsp_miss |->
      (rsp_data.hit_total == last_hit_ff) &&
      ((rsp_data.miss_total == last_miss_ff + 32'd1) ||
       ((last_miss_ff == '1) && (rsp_data.miss_total == '1))))

endmodule

bind column_associative_tag_store cats_checker u_cats_checker (.*);

`default_nettype wire

@@ verif/tag_store_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Column-associative tag store checker
// Watches both channels, predicts the outcome and counters of every accepted
// request and compares each response with the oldest prediction.
// ----------------------------------------------------------------------------

module tag_store_checker #(
   parameter int INDEX_BITS  = 8,
   parameter int TAG_BITS    = 19,
   parameter int OFFSET_BITS = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  cats_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  cats_pkg::rsp_type rsp_data,
   output int                in_flight,
   output int                mismatches
);

   import cats_pkg::*;

   localparam int LINES = 1 << INDEX_BITS;

   logic [TAG_BITS-1:0] tag_lines [LINES];
   logic [31:0]         hit_count;
   logic [31:0]         miss_count;
   rsp_type             predicted_rsp [$];

   initial begin
      in_flight  = 0;
      mismatches = 0;
   end

   // Updates the shadow tag store and counters exactly as one request would.
   function automatic rsp_type access_tag_store(input req_type item);
      logic [INDEX_BITS-1:0] line;
      logic [INDEX_BITS-1:0] twin;
      logic [TAG_BITS-1:0]   tag;
      outcome_type           kind;
      rsp_type               result;
      kind = OUT_IGNORED;
      if (item.cmd == CMD_FETCH) begin
         line = item.address[OFFSET_BITS +: INDEX_BITS];
         tag  = item.address[OFFSET_BITS + INDEX_BITS +: TAG_BITS];
         twin = ~line;
         if (tag_lines[line] == tag) begin
            kind = OUT_PRI_HIT;
         end else if (tag_lines[line] == '0) begin
            tag_lines[line] = tag;
            kind = OUT_MISS_FILL;
         end else if (tag_lines[twin] == tag) begin
            tag_lines[twin] = tag_lines[line];
            tag_lines[line] = tag;
            kind = OUT_ALT_HIT;
         end else begin
            tag_lines[twin] = tag;
            kind = OUT_MISS_REPL;
         end
         if (kind == OUT_PRI_HIT || kind == OUT_ALT_HIT) begin
            if (hit_count != '1) hit_count++;
         end else if (miss_count != '1) begin
            miss_count++;
         end
      end
      result.outcome    = kind;
      result.hit_total  = hit_count;
      result.miss_total = miss_count;
      return result;
   endfunction

   task automatic report_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $realtime, field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         foreach (tag_lines[k]) tag_lines[k] = '0;
         hit_count  = '0;
         miss_count = '0;
         predicted_rsp.delete();
      end else begin
         if (req_valid === 1'b1 && req_ready === 1'b1)
            predicted_rsp.push_back(access_tag_store(req_data));
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            if (predicted_rsp.size() == 0) begin
               $display("%0t: response with no request outstanding, got %h",
                        $realtime, rsp_data);
               mismatches++;
            end else begin
               want = predicted_rsp.pop_front();
               report_field("outcome", 32'(want.outcome), 32'(rsp_data.outcome));
               report_field("hit_total", want.hit_total, rsp_data.hit_total);
               report_field("miss_total", want.miss_total, rsp_data.miss_total);
            end
         end
      end
      // Registered so that the stimulus sees a count that is settled for this edge.
      in_flight <= predicted_rsp.size();
   end

endmodule

@@ verif/tb_column_associative_tag_store.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Column-associative tag store testbench
// Drives directed and random fetch streams with random gaps on both sides,
// while the checker predicts every response, and reports the verdict.
// ----------------------------------------------------------------------------

module tb_column_associative_tag_store;

   import cats_pkg::*;

   localparam int INDEX_BITS   = 8;
   localparam int TAG_BITS     = 19;
   localparam int OFFSET_BITS  = 5;
   localparam int RANDOM_ITEMS = 1750;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;

   localparam logic [2:0] CMD_READ    = 3'd0;
   localparam logic [2:0] CMD_WRITE   = 3'd1;
   localparam logic [2:0] CMD_UNKNOWN = 3'd3;
   localparam logic [2:0] CMD_FLUSH   = 3'd4;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      in_flight;
   int      mismatches;
   int      cycle_count = 0;
   bit      req_rush    = 1'b0;

   always #5 clock = ~clock;

   column_associative_tag_store #(
      .INDEX_BITS  (INDEX_BITS),
      .TAG_BITS    (TAG_BITS),
      .OFFSET_BITS (OFFSET_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   tag_store_checker #(
      .INDEX_BITS  (INDEX_BITS),
      .TAG_BITS    (TAG_BITS),
      .OFFSET_BITS (OFFSET_BITS)
   ) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .in_flight  (in_flight),
      .mismatches (mismatches)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic [31:0] line_addr(input logic [TAG_BITS-1:0] tag,
                                             input logic [INDEX_BITS-1:0] line,
                                             input logic [OFFSET_BITS-1:0] offset);
      return {tag, line, offset};
   endfunction

   // Offers one request and returns at the edge where it is accepted.
   task automatic send_request(input logic [2:0] cmd, input logic [31:0] address);
      int      gap;
      req_type item;
      item.cmd     = cmd;
      item.address = address;
      gap = req_rush ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   // Response side: random stalls, bursts of none, and one long hold-off.
   initial begin : drain
      int gap;
      int taken;
      bit rush;
      taken = 0;
      rush  = 1'b0;
      @(posedge clock);
      forever begin
         if (taken % 50 == 0) rush = ($urandom_range(0, 3) == 0);
         gap = rush ? 0 : $urandom_range(0, 15);
         if (taken == 400) gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_ready === 1'b1));
         taken++;
      end
   end

   initial begin : stimulus
      logic [TAG_BITS-1:0]   tag_pool [6];
      logic [INDEX_BITS-1:0] line_pool [4];
      logic [TAG_BITS-1:0]   tag;
      logic [INDEX_BITS-1:0] line;
      logic [2:0]            cmd;
      int                    pick;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Primary hit on an empty line with a zero tag.
      send_request(CMD_FETCH, 32'h0000_0000);
      send_request(CMD_FETCH, line_addr(19'h1_2345, 8'd5, 5'd3));
      // The offset plays no part in the lookup.
      send_request(CMD_FETCH, line_addr(19'h1_2345, 8'd5, 5'd31));
      // A second tag on the same index evicts into the inverted line, then swaps.
      send_request(CMD_FETCH, line_addr(19'h0_6789, 8'd5, 5'd0));
      send_request(CMD_FETCH, line_addr(19'h0_6789, 8'd5, 5'd7));
      send_request(CMD_FETCH, line_addr(19'h0_6789, 8'd5, 5'd1));
      send_request(CMD_FETCH, line_addr(19'h1_2345, 8'd5, 5'd2));
      send_request(CMD_FETCH, line_addr(19'h7_0F0F, 8'd5, 5'd4));
      // A zero tag finds the empty inverted line and swaps with it.
      send_request(CMD_FETCH, line_addr(19'h3_AAAA, 8'd10, 5'd0));
      send_request(CMD_FETCH, line_addr(19'h0_0000, 8'd10, 5'd9));
      send_request(CMD_FETCH, line_addr(19'h3_AAAA, 8'd10, 5'd0));
      send_request(CMD_FETCH, 32'hFFFF_FFFF);
      send_request(CMD_FETCH, line_addr('1, 8'd0, 5'd0));
      send_request(CMD_FETCH, 32'hFFFF_FFFF);
      // Commands other than a fetch leave everything untouched.
      send_request(CMD_READ, 32'hFFFF_FFFF);
      send_request(CMD_WRITE, 32'h0000_0000);
      send_request(CMD_UNKNOWN, line_addr(19'h1_2345, 8'd5, 5'd0));
      send_request(CMD_FLUSH, 32'hFFFF_FFFF);
      send_request(3'd5, $urandom);
      send_request(3'd6, $urandom);
      send_request(3'd7, 32'hFFFF_FFFF);
      send_request(CMD_FETCH, line_addr(19'h1_2345, 8'd5, 5'd0));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // A small working set keeps lines contended, so swaps and evictions occur.
         if (n % 250 == 0) begin
            foreach (tag_pool[k])
               tag_pool[k] = TAG_BITS'($urandom_range(1, (1 << TAG_BITS) - 1));
            foreach (line_pool[k]) line_pool[k] = INDEX_BITS'($urandom);
            if (n == 500) tag_pool[0] = '1;
         end
         if (n % 50 == 0) req_rush = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_ITEMS / 2) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (in_flight != 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            cmd = 3'($urandom_range(0, 6));
            if (cmd >= CMD_FETCH) cmd++;
            send_request(cmd, $urandom);
         end else if (pick < 14) begin
            send_request(CMD_FETCH, $urandom);
         end else begin
            line = line_pool[$urandom_range(0, 3)];
            if ($urandom_range(0, 1) == 1) line = ~line;
            tag = ($urandom_range(0, 19) == 0) ? '0 : tag_pool[$urandom_range(0, 5)];
            send_request(CMD_FETCH, line_addr(tag, line, OFFSET_BITS'($urandom)));
         end
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (in_flight != 0);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
